@@ src/qalu_pkg.sv @@
package qalu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int MAG_W     = 16 + FRAC_BITS;
    localparam int REM_W     = 17;
    localparam int NST       = MAG_W + 1;

    localparam logic [2:0] CMD_ADD16 = 3'd0;
    localparam logic [2:0] CMD_SUB16 = 3'd1;
    localparam logic [2:0] CMD_MUL16 = 3'd2;
    localparam logic [2:0] CMD_MUL32 = 3'd3;
    localparam logic [2:0] CMD_DIV16 = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic               dz;
    } req_t;

    typedef struct packed {
        logic [2:0]       command;
        logic [31:0]      res;
        logic             ovf;
        logic             dz;
        logic [63:0]      prod;
        logic             neg;
        logic [MAG_W-1:0] num;
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dvs;
        logic             qneg;
    } stage_t;

endpackage

@@ src/qalu_if.sv @@
interface qalu_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input command, input operand_a, input operand_b,
                  output ready);
endinterface

interface qalu_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               overflow;
    logic               divide_by_zero;

    modport source (output valid, output result, output overflow, output divide_by_zero,
                    input ready);
    modport sink (input valid, input result, input overflow, input divide_by_zero,
                  output ready);
endinterface

@@ src/qalu_front.sv @@
module qalu_front
    import qalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    qalu_req_if.sink    req,
    output logic        item_valid,
    input  logic        item_ready,
    output req_t        item
);

    logic vld_reg;
    req_t item_reg;
    req_t item_next;

    assign req.ready = !vld_reg || item_ready;

    always_comb
    begin
        item_next.command   = req.command;
        item_next.operand_a = req.operand_a;
        item_next.operand_b = req.operand_b;
        item_next.dz        = (req.command == CMD_DIV16) && (req.operand_b[15:0] == 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

@@ src/qalu_queue.sv @@
module qalu_queue
    import qalu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  req_t wr_item,
    output logic rd_valid,
    input  logic rd_ready,
    output req_t rd_item
);

    req_t       mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ src/qalu_back.sv @@
module qalu_back
    import qalu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  req_t      item,
    qalu_rsp_if.source rsp
);

    localparam logic [63:0] HALF    = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] LIM32_P = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM32_N = 64'h0000_0000_8000_0000;
    localparam logic [63:0] LIM16_P = 64'h0000_0000_0000_7FFF;
    localparam logic [63:0] LIM16_N = 64'h0000_0000_0000_8000;

    stage_t      st_reg  [0:NST-1];
    stage_t      st_next [0:NST-1];
    logic        vld_reg [0:NST-1];
    logic        adv;

    logic        rsp_vld_reg;
    logic [31:0] res_reg;
    logic        ovf_reg;
    logic        dz_reg;
    logic [31:0] res_next;
    logic        ovf_next;

    logic signed [15:0] a16;
    logic signed [15:0] b16;
    logic signed [16:0] sum17;
    logic [15:0]        diff16;
    logic signed [31:0] ma;
    logic signed [31:0] mb;
    logic [15:0]        mag_a;
    logic [15:0]        mag_b;

    assign adv        = !rsp_vld_reg || rsp.ready;
    assign item_ready = adv;

    always_comb
    begin
        logic [REM_W-1:0] t;
        logic             qbit;
        a16    = item.operand_a[15:0];
        b16    = item.operand_b[15:0];
        sum17  = 17'(a16) + 17'(b16);
        diff16 = 16'(a16 - b16);
        ma     = (item.command == CMD_MUL16) ? 32'(a16) : item.operand_a;
        mb     = (item.command == CMD_MUL16) ? 32'(b16) : item.operand_b;
        mag_a  = a16[15] ? 16'(~a16 + 16'sd1) : 16'(a16);
        mag_b  = b16[15] ? 16'(~b16 + 16'sd1) : 16'(b16);

        st_next[0]         = '0;
        st_next[0].command = item.command;
        st_next[0].dz      = item.dz;
        st_next[0].prod    = ma * mb;
        st_next[0].num     = (MAG_W'(mag_a) << FRAC_BITS) + MAG_W'(mag_b >> 1);
        st_next[0].dvs     = REM_W'(mag_b);
        st_next[0].qneg    = a16[15] ^ b16[15];
        unique case (item.command)
            CMD_ADD16:
            begin
                if (sum17[16] != sum17[15])
                begin
                    st_next[0].ovf = 1'b1;
                    st_next[0].res = sum17[16] ? 32'hFFFF_8000 : 32'h0000_7FFF;
                end
                else
                begin
                    st_next[0].res = 32'(sum17[15:0]) | {{16{sum17[15]}}, 16'd0};
                end
            end
            CMD_SUB16:
            begin
                st_next[0].res = {{16{diff16[15]}}, diff16};
            end
            default:
            begin
                st_next[0].res = '0;
            end
        endcase

        for (int k = 1; k < NST; k++)
        begin
            st_next[k] = st_reg[k-1];
            t          = {st_reg[k-1].rem[REM_W-2:0], st_reg[k-1].num[MAG_W-1]};
            qbit       = (t >= st_reg[k-1].dvs);
            st_next[k].rem = qbit ? (t - st_reg[k-1].dvs) : t;
            st_next[k].num = {st_reg[k-1].num[MAG_W-2:0], qbit};
            if (k == 1)
            begin
                st_next[k].neg  = st_reg[k-1].prod[63];
                st_next[k].prod = st_reg[k-1].prod[63] ? (~st_reg[k-1].prod + 64'd1)
                                                       : st_reg[k-1].prod;
            end
            else if (k == 2)
            begin
                st_next[k].prod = (st_reg[k-1].prod + HALF) >> FRAC_BITS;
            end
            else if (k == 3)
            begin
                if (st_reg[k-1].command == CMD_MUL32)
                begin
                    if (st_reg[k-1].neg && st_reg[k-1].prod > LIM32_N)
                    begin
                        st_next[k].ovf = 1'b1;
                        st_next[k].res = 32'h8000_0000;
                    end
                    else if (!st_reg[k-1].neg && st_reg[k-1].prod > LIM32_P)
                    begin
                        st_next[k].ovf = 1'b1;
                        st_next[k].res = 32'h7FFF_FFFF;
                    end
                    else
                    begin
                        st_next[k].res = st_reg[k-1].neg ? (~st_reg[k-1].prod[31:0] + 32'd1)
                                                         : st_reg[k-1].prod[31:0];
                    end
                end
                else if (st_reg[k-1].command == CMD_MUL16)
                begin
                    if (st_reg[k-1].neg && st_reg[k-1].prod > LIM16_N)
                    begin
                        st_next[k].ovf = 1'b1;
                        st_next[k].res = 32'hFFFF_8000;
                    end
                    else if (!st_reg[k-1].neg && st_reg[k-1].prod > LIM16_P)
                    begin
                        st_next[k].ovf = 1'b1;
                        st_next[k].res = 32'h0000_7FFF;
                    end
                    else
                    begin
                        st_next[k].res = st_reg[k-1].neg ? (~st_reg[k-1].prod[31:0] + 32'd1)
                                                         : st_reg[k-1].prod[31:0];
                    end
                end
            end
        end
    end

    always_comb
    begin
        logic [MAG_W-1:0] q;
        logic [15:0]      q16;
        q        = st_reg[NST-1].num;
        q16      = st_reg[NST-1].qneg ? (~q[15:0] + 16'd1) : q[15:0];
        res_next = st_reg[NST-1].res;
        ovf_next = st_reg[NST-1].ovf;
        if (st_reg[NST-1].command == CMD_DIV16)
        begin
            if (st_reg[NST-1].dz)
            begin
                res_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                res_next = {{16{q16[15]}}, q16};
                ovf_next = st_reg[NST-1].qneg ? (q > MAG_W'(32768)) : (q > MAG_W'(32767));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            rsp_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int k = 1; k < NST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            rsp_vld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            res_reg <= res_next;
            ovf_reg <= ovf_next;
            dz_reg  <= st_reg[NST-1].dz;
        end
    end

    assign rsp.valid          = rsp_vld_reg;
    assign rsp.result         = res_reg;
    assign rsp.overflow       = ovf_reg;
    assign rsp.divide_by_zero = dz_reg;

endmodule

@@ src/q_format_rounding_alu.sv @@
// Throughput: one item per cycle while the response side accepts results;
// the divider is a chain of one-bit restoring stages.
// The front register and a two-item queue let input and back end stall on their own.
// Reset (rst_n low, asynchronous) empties the front, queue and pipeline valid bits.
module q_format_rounding_alu
    import qalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    qalu_req_if.sink    req,
    qalu_rsp_if.source  rsp
);

    logic f_valid;
    logic f_ready;
    req_t f_item;
    logic q_valid;
    logic q_ready;
    req_t q_item;

    qalu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    qalu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    qalu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .rsp        (rsp)
    );

endmodule

@@ src/qalu_checker.sv @@
module qalu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_result,
    input logic        rsp_overflow,
    input logic        rsp_divide_by_zero
);

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_divide_by_zero |-> rsp_result == 32'd0 && !rsp_overflow)
        else $error("divide by zero item with nonzero result or overflow");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
            && $stable(rsp_overflow) && $stable(rsp_divide_by_zero))
        else $error("stalled result item changed");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !rsp_valid)
        else $error("result item right after reset");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_overflow && rsp_divide_by_zero))
        else $error("both flags set");

endmodule

bind q_format_rounding_alu qalu_checker u_qalu_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_result         (rsp.result),
    .rsp_overflow       (rsp.overflow),
    .rsp_divide_by_zero (rsp.divide_by_zero)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
    import qalu_pkg::*;
();

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } alu_op_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               overflow;
        logic               divide_by_zero;
    } alu_res_t;

    localparam int LATENCY = FRAC_BITS + 19;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qalu_req_if req ();
    qalu_rsp_if rsp ();

    q_format_rounding_alu DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    alu_op_t  pending_ops[$];
    alu_res_t expected_res[$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       ops_sent = 0;
    bit       stim_done = 1'b0;
    bit       hold_rsp = 1'b0;

    function automatic longint round_mag(longint p);
        longint mag;
        longint r;
        mag = (p < 0) ? -p : p;
        r = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (p < 0) ? -r : r;
    endfunction

    function automatic alu_res_t alu_predict(alu_op_t op);
        alu_res_t r;
        longint a16, b16, a32, b32, v;
        int num, half, q;
        logic [15:0] w;
        r = '0;
        a16 = longint'($signed(op.operand_a[15:0]));
        b16 = longint'($signed(op.operand_b[15:0]));
        a32 = longint'(op.operand_a);
        b32 = longint'(op.operand_b);
        case (op.command)
            CMD_ADD16, CMD_MUL16:
            begin
                v = (op.command == CMD_ADD16) ? a16 + b16 : round_mag(a16 * b16);
                if (v > 32767) begin v = 32767; r.overflow = 1'b1; end
                else if (v < -32768) begin v = -32768; r.overflow = 1'b1; end
                r.result = 32'(v);
            end
            CMD_SUB16:
            begin
                w = 16'(a16 - b16);
                r.result = 32'($signed(w));
            end
            CMD_MUL32:
            begin
                v = round_mag(a32 * b32);
                if (v > 64'sd2147483647) begin v = 64'sd2147483647; r.overflow = 1'b1; end
                else if (v < -64'sd2147483648)
                begin
                    v = -64'sd2147483648;
                    r.overflow = 1'b1;
                end
                r.result = 32'(v);
            end
            CMD_DIV16:
            begin
                if (b16 == 0) r.divide_by_zero = 1'b1;
                else
                begin
                    num = int'(a16) <<< FRAC_BITS;
                    half = int'(b16) / 2;
                    if ((num < 0) != (b16 < 0)) num = num - half;
                    else num = num + half;
                    q = num / int'(b16);
                    if (q > 32767 || q < -32768) r.overflow = 1'b1;
                    w = q[15:0];
                    r.result = 32'($signed(w));
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff ^ ($urandom_range(0, 3));
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'($signed(16'($urandom)));
            3: return 32'($urandom_range(0, 1024)) - 32'd512;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(logic [2:0] c, logic [31:0] a, logic [31:0] b);
        alu_op_t op;
        op.command = c;
        op.operand_a = a;
        op.operand_b = b;
        pending_ops.push_back(op);
    endtask

    initial
    begin
        logic [2:0] c;
        push_op(CMD_ADD16, 32'h0000_7fff, 32'h0000_0001);
        push_op(CMD_ADD16, 32'hffff_8000, 32'hffff_ffff);
        push_op(CMD_ADD16, 32'h1234_0100, 32'hffff_0200);
        push_op(CMD_SUB16, 32'h0000_8000, 32'h0000_0001);
        push_op(CMD_SUB16, 32'h0000_7fff, 32'hffff_ffff);
        push_op(CMD_MUL16, 32'h0000_0180, 32'h0000_0001);
        push_op(CMD_MUL16, 32'hffff_fe80, 32'h0000_0001);
        push_op(CMD_MUL16, 32'h0000_7fff, 32'h0000_7fff);
        push_op(CMD_MUL16, 32'h0000_8000, 32'h0000_8000);
        push_op(CMD_MUL16, 32'h0000_8000, 32'h0000_7fff);
        push_op(CMD_MUL32, 32'h7fff_ffff, 32'h7fff_ffff);
        push_op(CMD_MUL32, 32'h8000_0000, 32'h8000_0000);
        push_op(CMD_MUL32, 32'h8000_0000, 32'h7fff_ffff);
        push_op(CMD_MUL32, 32'hffff_ff80, 32'h0000_0001);
        push_op(CMD_MUL32, 32'h0000_0100, 32'hffff_ffff);
        push_op(CMD_DIV16, 32'h0000_0100, 32'h0000_0000);
        push_op(CMD_DIV16, 32'h0000_7fff, 32'h0000_0001);
        push_op(CMD_DIV16, 32'h0000_8000, 32'h0000_0001);
        push_op(CMD_DIV16, 32'h0000_8000, 32'hffff_ffff);
        push_op(CMD_DIV16, 32'h0000_0100, 32'h0000_0300);
        push_op(CMD_DIV16, 32'hffff_ff00, 32'h0000_0300);
        push_op(CMD_DIV16, 32'h0000_0001, 32'hffff_8000);
        push_op(3'd5, 32'hffff_ffff, 32'hffff_ffff);
        push_op(3'd6, 32'h1234_5678, 32'h0);
        push_op(3'd7, 32'h0, 32'h8765_4321);
        repeat (750)
        begin
            c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            push_op(c, pick_operand(),
                    ($urandom_range(0, 15) == 0) ? 32'($urandom) & 32'hffff_0000
                                                 : pick_operand());
        end
        stim_done = 1'b1;
    end

    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.command <= '0;
            req.operand_a <= '0;
            req.operand_b <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_res.push_back(alu_predict({req.command, req.operand_a,
                                                    req.operand_b}));
                ops_sent++;
            end
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    req.valid <= 1'b1;
                    {req.command, req.operand_a, req.operand_b} <= pending_ops.pop_front();
                    if (burst_left > 0) burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else req.valid <= 1'b0;
            end
        end
    end

    int stall_phase = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rsp.ready <= 1'b0;
        else
        begin
            stall_phase = (stall_phase + 1) % 23;
            if (hold_rsp) rsp.ready <= 1'b0;
            else if (stall_phase < 8) rsp.ready <= 1'b1;
            else rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        wait (rst_n);
        wait (ops_sent >= 300);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (150) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    always @(posedge clk)
    begin
        alu_res_t got, want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = {rsp.result, rsp.overflow, rsp.divide_by_zero};
            results_seen++;
            if (expected_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %p", got);
            end
            else
            begin
                want = expected_res.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h ovf %b dz %b, got %h ovf %b dz %b",
                                 want.result, want.overflow, want.divide_by_zero,
                                 got.result, got.overflow, got.divide_by_zero);
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && pending_ops.size() == 0 && !req.valid);
        wait (expected_res.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        mismatches += expected_res.size();
        $display("run covered %0d items over all five commands and the unused codes, %0d results",
                 ops_sent, results_seen);
        $display("including saturation, rounding halves, wrapped quotients, zero divisors");
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
